FILE: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // decoder phase
    typedef enum logic [2:0] {
        PH_SIZE      = 3'd0,
        PH_EXT       = 3'd1,
        PH_SIZE_LF   = 3'd2,
        PH_DATA      = 3'd3,
        PH_DATA_LF   = 3'd4,
        PH_DONE      = 3'd5,
        PH_FMT_ERR   = 3'd6,
        PH_TOO_LARGE = 3'd7
    } t_phase;

    // status codes on the result word
    localparam logic [1:0] ST_RUN       = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_FMT_ERR   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // characters of the chunk framing
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;

    // body total width: one bit above the 32-bit limit register
    localparam int TOTAL_BITS = 33;

    // register byte address width; its top bit selects the register index
    localparam int ADDR_BITS = 3;

    // one result word
    typedef struct packed {
        logic       data_valid;
        logic [7:0] out_byte;
        logic [1:0] status;
    } t_result;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [1:0] status_of(input t_phase ph);
        logic [1:0] s;
        case (ph)
            PH_DONE:      s = ST_DONE;
            PH_FMT_ERR:   s = ST_FMT_ERR;
            PH_TOO_LARGE: s = ST_TOO_LARGE;
            default:      s = ST_RUN;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// HTTP/1.1 chunked transfer body decoder, one raw byte per clock while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one raw body byte per word with
//   i_new_message, which clears the decoder before that byte is handled.
//   Output channel (o_valid / i_stall) carries one result word per input
//   word: o_data_valid and o_out_byte for decoded body bytes, and o_status
//   (in progress, complete, format error, too large).
//   o_valid rises in the cycle after input accept. Throughput is one byte
//   per clock unless the receiver stalls: the whole decode step is a single
//   pass of logic from decoder state and input byte into the result register.
//   When the receiver stalls, the result register holds and o_stall goes
//   high, so no further byte is taken until the result is consumed.
//   The max_body_bytes limit is written over the APB port at address 0.
//   A synchronous reset clears the decoder state, empties the result
//   register and sets the limit to 1 MiB. Done and error states hold until
//   a byte arrives with i_new_message set.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_new_message,
    input  logic [7:0]            i_in_byte,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_data_valid,
    output logic [7:0]            o_out_byte,
    output logic [1:0]            o_status,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    t_phase                r_phase, n_phase;
    logic [SIZE_BITS-1:0]  r_chunk, n_chunk;
    logic                  r_seen, n_seen;
    logic [SIZE_BITS-1:0]  r_remain, n_remain;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic [31:0]           r_max_body;
    logic                  r_out_valid;
    t_result               r_res, n_res;
    logic                  accept;
    logic                  reg_sel;

    // handshake
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // decode step
    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_phase       (r_phase),
        .i_chunk       (r_chunk),
        .i_seen        (r_seen),
        .i_remain      (r_remain),
        .i_total       (r_total),
        .i_new_message (i_new_message),
        .i_in_byte     (i_in_byte),
        .i_max_body    (r_max_body),
        .o_phase       (n_phase),
        .o_chunk       (n_chunk),
        .o_seen        (n_seen),
        .o_remain      (n_remain),
        .o_total       (n_total),
        .o_result      (n_res)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIZE;
            r_chunk  <= '0;
            r_seen   <= 1'b0;
            r_remain <= '0;
            r_total  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_chunk  <= n_chunk;
            r_seen   <= n_seen;
            r_remain <= n_remain;
            r_total  <= n_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_valid = r_res.data_valid;
    assign o_out_byte   = r_res.out_byte;
    assign o_status     = r_res.status;

    // configuration register
    assign reg_sel = ~paddr[ADDR_BITS-1];
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? r_max_body : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_body <= pwdata;
        end
    end

    // checks
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result word held");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted byte produced no result word");

    a_data_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data_valid) |-> (o_status == ST_RUN))
        else $error("data byte with terminal status");

    a_terminal_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_new_message && (r_phase == PH_DONE || r_phase == PH_FMT_ERR
            || r_phase == PH_TOO_LARGE))
        |=> (!o_data_valid && o_status == $past(status_of(r_phase))))
        else $error("terminal state did not hold");

endmodule

FILE: rtl/hcbd_step.sv
// ----------------------------------------------------------------------------
// hcbd_step
// Single-byte decode step: next decoder state and the result word.
// ----------------------------------------------------------------------------
module hcbd_step
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  t_phase                  i_phase,
    input  logic [SIZE_BITS-1:0]    i_chunk,
    input  logic                    i_seen,
    input  logic [SIZE_BITS-1:0]    i_remain,
    input  logic [TOTAL_BITS-1:0]   i_total,
    input  logic                    i_new_message,
    input  logic [7:0]              i_in_byte,
    input  logic [31:0]             i_max_body,
    output t_phase                  o_phase,
    output logic [SIZE_BITS-1:0]    o_chunk,
    output logic                    o_seen,
    output logic [SIZE_BITS-1:0]    o_remain,
    output logic [TOTAL_BITS-1:0]   o_total,
    output t_result                 o_result
);

    t_phase                ph;
    logic [SIZE_BITS-1:0]  chunk;
    logic                  seen;
    logic [SIZE_BITS-1:0]  remain;
    logic [TOTAL_BITS-1:0] total;
    t_hex                  hx;
    logic                  dv;

    always_comb begin
        // new message clears the state before this byte
        if (i_new_message) begin
            ph     = PH_SIZE;
            chunk  = '0;
            seen   = 1'b0;
            remain = '0;
            total  = '0;
        end else begin
            ph     = i_phase;
            chunk  = i_chunk;
            seen   = i_seen;
            remain = i_remain;
            total  = i_total;
        end

        hx       = hex_decode(i_in_byte);
        dv       = 1'b0;
        o_phase  = ph;
        o_chunk  = chunk;
        o_seen   = seen;
        o_remain = remain;
        o_total  = total;

        unique case (ph)
            PH_SIZE: begin
                if (hx.ok) begin
                    // top digit occupied: another digit would overflow
                    if (chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                        o_phase = PH_FMT_ERR;
                    end else begin
                        o_chunk = {chunk[SIZE_BITS-5:0], hx.val};
                        o_seen  = 1'b1;
                    end
                end else if (i_in_byte == CH_SEMI) begin
                    o_phase = seen ? PH_EXT : PH_FMT_ERR;
                end else if (i_in_byte == CH_CR) begin
                    o_phase = seen ? PH_SIZE_LF : PH_FMT_ERR;
                end else begin
                    o_phase = PH_FMT_ERR;
                end
            end
            PH_EXT: begin
                if (i_in_byte == CH_CR) begin
                    o_phase = PH_SIZE_LF;
                end
            end
            PH_SIZE_LF: begin
                if (i_in_byte != CH_LF) begin
                    o_phase = PH_FMT_ERR;
                end else if (chunk == '0) begin
                    o_phase = PH_DONE;
                end else begin
                    o_remain = chunk;
                    o_chunk  = '0;
                    o_seen   = 1'b0;
                    o_phase  = PH_DATA;
                end
            end
            PH_DATA: begin
                if (remain != '0) begin
                    dv       = 1'b1;
                    o_remain = remain - {{(SIZE_BITS-1){1'b0}}, 1'b1};
                    // total saturates at 2^32
                    if (!total[TOTAL_BITS-1]) begin
                        o_total = total + {{(TOTAL_BITS-1){1'b0}}, 1'b1};
                    end
                end else if (i_in_byte == CH_CR) begin
                    o_phase = PH_DATA_LF;
                end else begin
                    o_phase = PH_FMT_ERR;
                end
            end
            PH_DATA_LF: begin
                if (i_in_byte != CH_LF) begin
                    o_phase = PH_FMT_ERR;
                end else if (total > {1'b0, i_max_body}) begin
                    o_phase = PH_TOO_LARGE;
                end else begin
                    o_phase = PH_SIZE;
                end
            end
            PH_DONE, PH_FMT_ERR, PH_TOO_LARGE: begin
                // terminal phases hold until a new message
            end
            default: begin
            end
        endcase

        o_result.data_valid = dv;
        o_result.out_byte   = dv ? i_in_byte : 8'd0;
        o_result.status     = status_of(o_phase);
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the chunked body decoder. It feeds framed messages, both
// well-formed and damaged, one byte per word, while the sender idles in bursts
// and the receiver stalls. A cycle-free model of the decoder predicts each
// result word, and the result channel is checked word by word. The body limit
// is rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import hcbd_pkg::*;

    localparam int          IDLE_LIMIT    = 4000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          IDX_MAX_BODY  = 0;
    localparam int          IDX_UNUSED    = 1;
    localparam logic [7:0]  CH_ZERO       = 8'h30;
    localparam logic [7:0]  CH_UPPER_A    = 8'h41;
    localparam logic [7:0]  CH_LOWER_A    = 8'h61;
    localparam logic [7:0]  CH_LOWER_G    = 8'h67;
    localparam logic [31:0] LIMIT_RESET   = 32'd1048576;
    localparam logic [32:0] TOTAL_CEILING = 33'h1_0000_0000;

    // dut ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic                 i_new_message = 1'b0;
    logic [7:0]           i_in_byte     = 8'd0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic                 o_data_valid;
    logic [7:0]           o_out_byte;
    logic [1:0]           o_status;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_BITS-1:0] paddr         = '0;
    logic [31:0]          pwdata        = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;

    // decoder model state
    t_phase      ph            = PH_SIZE;
    logic [31:0] size_acc      = 32'd0;
    logic        have_digit    = 1'b0;
    logic [31:0] left_in_chunk = 32'd0;
    logic [32:0] decoded_total = 33'd0;
    logic [31:0] body_limit    = LIMIT_RESET;

    // result words still due, oldest first
    t_result     pending_results[$];
    logic [7:0]  msg_bytes[$];
    int          fault_count   = 0;
    int          burst_left    = 0;
    int          idle_cycles   = 0;
    int          stall_mode    = 0;
    int          stall_tick    = 0;
    t_result     got_word;
    t_result     want_word;

    http_chunked_body_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_new_message (i_new_message),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_valid  (o_data_valid),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function automatic int digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c) - int'(CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return int'(c) - int'(CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c) - int'(CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic logic [1:0] phase_status(input t_phase p);
        case (p)
            PH_DONE:      return ST_DONE;
            PH_FMT_ERR:   return ST_FMT_ERR;
            PH_TOO_LARGE: return ST_TOO_LARGE;
            default:      return ST_RUN;
        endcase
    endfunction

    function automatic t_result decode_byte(input logic nm, input logic [7:0] c);
        t_result r;
        int      d;
        r = '0;
        if (nm) begin
            ph            = PH_SIZE;
            size_acc      = 32'd0;
            have_digit    = 1'b0;
            left_in_chunk = 32'd0;
            decoded_total = 33'd0;
        end
        d = digit_value(c);
        case (ph)
            PH_SIZE: begin
                if (d >= 0) begin
                    // one more digit must not push the size past 32 bits
                    if (size_acc[31:28] != 4'd0) begin
                        ph = PH_FMT_ERR;
                    end else begin
                        size_acc   = {size_acc[27:0], d[3:0]};
                        have_digit = 1'b1;
                    end
                end else if (c == CH_SEMI) begin
                    ph = have_digit ? PH_EXT : PH_FMT_ERR;
                end else if (c == CH_CR) begin
                    ph = have_digit ? PH_SIZE_LF : PH_FMT_ERR;
                end else begin
                    ph = PH_FMT_ERR;
                end
            end
            PH_EXT: begin
                if (c == CH_CR) ph = PH_SIZE_LF;
            end
            PH_SIZE_LF: begin
                if (c != CH_LF) begin
                    ph = PH_FMT_ERR;
                end else if (size_acc == 32'd0) begin
                    ph = PH_DONE;
                end else begin
                    left_in_chunk = size_acc;
                    size_acc      = 32'd0;
                    have_digit    = 1'b0;
                    ph            = PH_DATA;
                end
            end
            PH_DATA: begin
                if (left_in_chunk != 32'd0) begin
                    r.data_valid  = 1'b1;
                    r.out_byte    = c;
                    left_in_chunk = left_in_chunk - 32'd1;
                    if (decoded_total < TOTAL_CEILING) decoded_total = decoded_total + 33'd1;
                end else if (c == CH_CR) begin
                    ph = PH_DATA_LF;
                end else begin
                    ph = PH_FMT_ERR;
                end
            end
            PH_DATA_LF: begin
                if (c != CH_LF) ph = PH_FMT_ERR;
                else if (decoded_total > {1'b0, body_limit}) ph = PH_TOO_LARGE;
                else ph = PH_SIZE;
            end
            default: ;
        endcase
        r.status = phase_status(ph);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: one word per call, bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_word(input logic nm, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        i_valid       <= 1'b1;
        i_new_message <= nm;
        i_in_byte     <= b;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(decode_byte(nm, b));
        burst_left--;
    endtask

    // hold off until every expected word has come back
    task automatic settle();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // apb write, setup then access
    task automatic write_reg(input int idx, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == IDX_MAX_BODY) body_limit = value;
    endtask

    // ------------------------------------------------------------------
    // message builder
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        if ($urandom_range(0, 1) == 1) return CH_UPPER_A + 8'(nib) - 8'd10;
        return CH_LOWER_A + 8'(nib) - 8'd10;
    endfunction

    task automatic add_size_line(input logic [31:0] v);
        int         nd;
        logic [7:0] b;
        // optional leading zeros
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) msg_bytes.push_back(CH_ZERO);
        end
        nd = 1;
        while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
        for (int i = nd - 1; i >= 0; i--) msg_bytes.push_back(hex_char(v[4*i +: 4]));
        // optional extension, any bytes but cr
        if ($urandom_range(0, 3) == 0) begin
            msg_bytes.push_back(CH_SEMI);
            repeat ($urandom_range(0, 4)) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_CR) b = CH_SEMI;
                msg_bytes.push_back(b);
            end
        end
        msg_bytes.push_back(CH_CR);
        msg_bytes.push_back(CH_LF);
    endtask

    // one message, mostly well formed, sometimes damaged
    task automatic build_message();
        int          flaw;
        int          len;
        logic [31:0] sz;
        msg_bytes.delete();
        flaw = $urandom_range(0, 19);
        if (flaw == 18) begin
            // nine significant digits overflow the size
            msg_bytes.push_back(8'h31);
            repeat (8) msg_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        repeat ($urandom_range(0, 3)) begin
            sz = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            add_size_line(sz);
            repeat (sz) msg_bytes.push_back(8'($urandom_range(0, 255)));
            msg_bytes.push_back(CH_CR);
            msg_bytes.push_back(CH_LF);
        end
        add_size_line(32'd0);
        // bytes after the end just see the held status
        repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        len = msg_bytes.size();
        if (flaw == 15 || flaw == 16) begin
            msg_bytes[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        end else if (flaw == 17) begin
            // cut short, the next message restarts the decoder mid-stream
            len = $urandom_range(1, len - 1);
            while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
        end
    endtask

    task automatic run_messages(input int n_words);
        int sent;
        sent = 0;
        while (sent < n_words) begin
            build_message();
            foreach (msg_bytes[i]) send_word(i == 0, msg_bytes[i]);
            sent += msg_bytes.size();
            // at least one full pause with nothing in flight
            if (sent >= n_words / 2 && sent - msg_bytes.size() < n_words / 2) settle();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_framing_directed();
        // empty body, then held done status
        send_word(1'b1, CH_ZERO);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, 8'hff);
        // one byte chunk with an empty extension
        send_word(1'b1, 8'h31);
        send_word(1'b0, CH_SEMI);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, 8'hff);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, CH_ZERO);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        // empty size line
        send_word(1'b1, CH_SEMI);
        send_word(1'b1, CH_CR);
        // bad size character
        send_word(1'b1, CH_LOWER_G);
        // bare cr on the size line
        send_word(1'b1, 8'h31);
        send_word(1'b0, CH_CR);
        send_word(1'b0, 8'h58);
        // missing cr after data
        send_word(1'b1, 8'h31);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h62);
        // size beyond 32 bits, mixed case digits
        send_word(1'b1, 8'h31);
        send_word(1'b0, CH_LOWER_A);
        send_word(1'b0, CH_UPPER_A + 8'd1);
        send_word(1'b0, CH_LOWER_A + 8'd2);
        send_word(1'b0, CH_UPPER_A + 8'd3);
        send_word(1'b0, CH_LOWER_A + 8'd4);
        send_word(1'b0, CH_UPPER_A + 8'd5);
        send_word(1'b0, CH_ZERO);
        send_word(1'b0, CH_ZERO + 8'd9);
    endtask

    task automatic test_default_limit();
        run_messages(220);
    endtask

    task automatic test_zero_limit();
        write_reg(IDX_MAX_BODY, 32'd0);
        // any data at all is too much
        send_word(1'b1, 8'h31);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, 8'h5a);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, CH_ZERO);
        run_messages(200);
    endtask

    task automatic test_small_limit();
        write_reg(IDX_MAX_BODY, $urandom_range(5, 40));
        run_messages(100);
        write_reg(IDX_MAX_BODY, $urandom_range(20, 80));
        run_messages(100);
    endtask

    task automatic test_full_limit();
        write_reg(IDX_MAX_BODY, 32'hffff_ffff);
        // writes past the only register are dropped
        write_reg(IDX_UNUSED, $urandom);
        run_messages(200);
    endtask

    // ------------------------------------------------------------------
    // result checker and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_word = {o_data_valid, o_out_byte, o_status};
            if (pending_results.size() == 0) begin
                if (fault_count < MAX_REPORTS)
                    $display("unexpected word: data_valid=%0b out_byte=%02h status=%0d",
                             got_word.data_valid, got_word.out_byte, got_word.status);
                fault_count++;
            end else begin
                want_word = pending_results.pop_front();
                if (got_word.data_valid !== want_word.data_valid ||
                    got_word.out_byte !== want_word.out_byte ||
                    got_word.status !== want_word.status) begin
                    if (fault_count < MAX_REPORTS)
                        $display("mismatch: expected dv=%0b byte=%02h st=%0d, got dv=%0b byte=%02h st=%0d",
                                 want_word.data_valid, want_word.out_byte, want_word.status,
                                 got_word.data_valid, got_word.out_byte, got_word.status);
                    fault_count++;
                end
            end
        end
        // periodic new stall pattern
        stall_tick++;
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 9) < 3);
            2:       i_stall <= (stall_tick % 7 < 3);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing_directed();
        test_default_limit();
        test_zero_limit();
        test_small_limit();
        test_full_limit();
        settle();
        repeat (5) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
